### src/first_fit_timed_allocator_top_assert.svh
// Assertion macros shared by the allocator RTL
`ifndef FIRST_FIT_TIMED_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_TIMED_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define FFTA_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define FFTA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ffta_pkg.sv
// Types and constants shared by the allocator modules
`timescale 1ns / 1ps

package ffta_pkg;

  localparam logic [30:0] TIME_MAX   = 31'h7FFF_FFFF;
  localparam logic [30:0] MEM_LIMIT  = 31'h4000_0000;
  localparam logic [30:0] RESET_SIZE = 31'd1024;
  localparam logic [19:0] COUNT_MAX  = 20'hF_FFFF;
  localparam logic [30:0] TIME_TOP   = 31'h4000_0000;

  typedef struct packed {
    logic        mode;
    logic [29:0] arrival_time;
    logic [30:0] length;
    logic [29:0] duration;
  } alloc_in_t;

  typedef struct packed {
    logic        placed_now;
    logic [29:0] start_address;
    logic [30:0] last_release_time;
    logic [19:0] queued_total;
    logic        overflow;
  } alloc_out_t;

  typedef struct packed {
    logic        valid;
    logic [30:0] start;
    logic [30:0] len;
    logic [30:0] rel;
  } run_entry_t;

  localparam run_entry_t ENTRY_NONE = '{valid: 1'b0, start: 31'd0, len: 31'd0, rel: 31'd0};

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PROBE_REL,
    CMD_PROBE_FIT,
    CMD_DELETE,
    CMD_COMPACT,
    CMD_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [30:0] key;
    logic [30:0] hi_mask;
    logic [30:0] bit_mask;
    logic [30:0] limit;
    logic [30:0] length;
    logic [30:0] rel_new;
    logic [30:0] size;
    logic        phase;
  } cell_cmd_t;

endpackage

### src/ffta_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module ffta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ffta_wait_fifo.sv
// Wait queue of deferred requests, held in RAM, oldest at the head
`timescale 1ns / 1ps

module ffta_wait_fifo #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [30:0]                push_len,
  input  logic [29:0]                push_dur,
  input  logic                       pop,
  output logic [30:0]                head_len,
  output logic [29:0]                head_dur,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [60:0]   rdata;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= wrap_inc(tail);
      end
      if (pop) begin
        head <= wrap_inc(head);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // head is read every cycle; data follows in the cycle after the pointer moves
  ffta_ram #(
    .WIDTH (61),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata ({push_len, push_dur}),
    .raddr (head),
    .rdata (rdata)
  );

  assign head_len = rdata[60:30];
  assign head_dur = rdata[29:0];

endmodule

### src/ffta_cell.sv
// One run-table cell: holds a placed block and talks to its two neighbors
`timescale 1ns / 1ps

module ffta_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ffta_pkg::cell_cmd_t   cmd,
  input  ffta_pkg::run_entry_t  left,
  input  ffta_pkg::run_entry_t  right,
  output ffta_pkg::run_entry_t  entry,
  output logic                  hit,
  output logic                  swap,
  output logic [30:0]           addr
);

  localparam logic        ODD   = (CELL_IDX % 2) == 1;
  localparam logic [30:0] IDX31 = 31'(CELL_IDX);

  logic        valid;
  logic [30:0] start;
  logic [30:0] len;
  logic [30:0] rel;

  logic        valid_next;
  logic [30:0] start_next;
  logic [30:0] len_next;
  logic [30:0] rel_next;

  logic [31:0] lo;
  logic [32:0] need;
  logic        first_slot;
  logic        fit;
  logic        rel_match;
  logic        idx_match;
  logic        left_role;

  assign entry = '{valid: valid, start: start, len: len, rel: rel};

  // gap below this cell starts at the end of the left neighbor
  assign lo         = left.valid ? ({1'b0, left.start} + {1'b0, left.len}) : 32'd0;
  assign need       = {1'b0, lo} + {2'b0, cmd.length};
  assign first_slot = (CELL_IDX == 0) || left.valid;
  assign fit        = valid ? (need <= {2'b0, start})
                            : (first_slot && (need <= {2'b0, cmd.size}));

  assign rel_match = (((rel ^ cmd.key) & cmd.hi_mask) == '0) && ((rel & cmd.bit_mask) == '0);
  assign idx_match = (((IDX31 ^ cmd.key) & cmd.hi_mask) == '0) &&
                     ((IDX31 & cmd.bit_mask) == '0);
  assign left_role = (ODD == cmd.phase);

  always_comb begin
    valid_next = valid;
    start_next = start;
    len_next   = len;
    rel_next   = rel;
    hit        = 1'b0;
    swap       = 1'b0;
    addr       = '0;
    unique case (cmd.op)
      ffta_pkg::CMD_PROBE_REL: begin
        hit = valid && (rel <= cmd.limit) && rel_match;
      end
      ffta_pkg::CMD_PROBE_FIT: begin
        hit = fit && idx_match;
      end
      ffta_pkg::CMD_DELETE: begin
        if (valid && (rel == cmd.key)) begin
          valid_next = 1'b0;
        end
      end
      ffta_pkg::CMD_COMPACT: begin
        // swap a hole with the block on its right, pairs alternate by phase
        if (left_role) begin
          if (!valid && right.valid) begin
            valid_next = 1'b1;
            start_next = right.start;
            len_next   = right.len;
            rel_next   = right.rel;
            swap       = 1'b1;
          end
        end else if ((CELL_IDX != 0) && valid && !left.valid) begin
          valid_next = 1'b0;
        end
      end
      ffta_pkg::CMD_INSERT: begin
        if (IDX31 == cmd.key) begin
          valid_next = 1'b1;
          start_next = lo[30:0];
          len_next   = cmd.length;
          rel_next   = cmd.rel_new;
          addr       = lo[30:0];
        end else if (IDX31 > cmd.key) begin
          valid_next = left.valid;
          start_next = left.start;
          len_next   = left.len;
          rel_next   = left.rel;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    start <= start_next;
    len   <= len_next;
    rel   <= rel_next;
  end

endmodule

### src/first_fit_timed_allocator_top.sv
// First-fit timed allocator: sequencer, run-table cell chain and wait queue
// One transaction in, one out. A request enters, is checked for a due release
// and leaves. Before that, each due release batch is retired: a bitwise minimum
// search over release times in the cell chain, a delete, compaction phases
// until the chain is quiet and a check of the wait queue, after which queued
// heads are read from the wait queue RAM and served by a fit search and an
// insert, until the queue is empty or a waiting head does not fit. In mode 0
// the request itself is then placed by a fit search and an insert. The cell chain
// runs one command per cycle, and each served head is read from the wait queue
// RAM in a state of its own. A new request is taken while the previous result still waits
// in the output register.
`timescale 1ns / 1ps
`include "first_fit_timed_allocator_top_assert.svh"

module first_fit_timed_allocator_top #(
  parameter int MAX_RUNS = 64,
  parameter int MAX_WAIT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ffta_pkg::alloc_in_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ffta_pkg::alloc_out_t  out_data,
  input  logic                  cfg_wr_en,
  input  logic [30:0]           cfg_wr_data
);

  localparam int          IW      = $clog2(MAX_RUNS);
  localparam int          CW      = $clog2(MAX_WAIT + 1);
  localparam logic [30:0] IDX_TOP = 31'd1 << (IW - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REL_ANY,
    S_REL_BIT,
    S_DEL,
    S_COMPACT,
    S_SERVE,
    S_HEAD,
    S_FIT_ANY,
    S_FIT_BIT,
    S_INS,
    S_DONE
  } state_t;

  state_t state;

  logic [30:0] mem_size;
  logic [30:0] eff_size;

  logic        item_mode;
  logic [30:0] item_time;
  logic [30:0] item_len;
  logic [29:0] item_dur;
  logic [30:0] limit;
  logic [30:0] fkey;
  logic [30:0] hi_mask;
  logic [30:0] bit_mask;
  logic        phase;
  logic        quiet;
  logic [30:0] p_len;
  logic [29:0] p_dur;
  logic [30:0] p_now;
  logic        p_fifo;
  logic [30:0] last_time;
  logic [19:0] waited_total;
  logic        res_placed;
  logic [30:0] res_addr;
  logic        res_ovf;

  ffta_pkg::cell_cmd_t  cmd;
  ffta_pkg::run_entry_t ent [MAX_RUNS];
  logic [MAX_RUNS-1:0]  hits;
  logic [MAX_RUNS-1:0]  swaps;
  logic [30:0]          addrs [MAX_RUNS];
  logic [MAX_RUNS-2:0]  gap_pair;
  logic                 compact_ok;
  logic                 hit_any;
  logic                 swap_any;
  logic [30:0]          addr_any;

  logic [31:0] rel_sum;
  logic [30:0] rel_new;
  logic [32:0] tail_need;
  logic        full;
  logic        tail_fit;
  logic        fit_any;
  logic [30:0] key_next;

  logic [30:0]   head_len;
  logic [29:0]   head_dur;
  logic [CW-1:0] fifo_count;
  logic          fifo_full;
  logic          push;
  logic          pop;

  assign eff_size = (mem_size > ffta_pkg::MEM_LIMIT) ? ffta_pkg::MEM_LIMIT : mem_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size <= ffta_pkg::RESET_SIZE;
    end else if (cfg_wr_en) begin
      mem_size <= cfg_wr_data;
    end
  end

  // release time saturates at the top of the time range
  assign rel_sum = {1'b0, p_now} + {2'b0, p_dur};
  assign rel_new = rel_sum[31] ? ffta_pkg::TIME_MAX : rel_sum[30:0];

  always_comb begin
    cmd          = '0;
    cmd.op       = ffta_pkg::CMD_HOLD;
    cmd.key      = fkey;
    cmd.hi_mask  = hi_mask;
    cmd.bit_mask = bit_mask;
    cmd.limit    = limit;
    cmd.length   = p_len;
    cmd.rel_new  = rel_new;
    cmd.size     = eff_size;
    cmd.phase    = phase;
    unique case (state)
      S_REL_ANY, S_REL_BIT: cmd.op = ffta_pkg::CMD_PROBE_REL;
      S_DEL:                cmd.op = ffta_pkg::CMD_DELETE;
      S_COMPACT:            cmd.op = ffta_pkg::CMD_COMPACT;
      S_FIT_ANY, S_FIT_BIT: cmd.op = ffta_pkg::CMD_PROBE_FIT;
      S_INS:                cmd.op = ffta_pkg::CMD_INSERT;
      default:              cmd.op = ffta_pkg::CMD_HOLD;
    endcase
  end

  for (genvar j = 0; j < MAX_RUNS; j++) begin : g_cell
    ffta_pkg::run_entry_t left_e;
    ffta_pkg::run_entry_t right_e;
    if (j == 0) begin : g_first
      assign left_e = ffta_pkg::ENTRY_NONE;
    end else begin : g_mid_l
      assign left_e = ent[j-1];
    end
    if (j == MAX_RUNS - 1) begin : g_last
      assign right_e = ffta_pkg::ENTRY_NONE;
    end else begin : g_mid_r
      assign right_e = ent[j+1];
      assign gap_pair[j] = !ent[j].valid && ent[j+1].valid;
    end
    ffta_cell #(
      .CELL_IDX (j)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (left_e),
      .right (right_e),
      .entry (ent[j]),
      .hit   (hits[j]),
      .swap  (swaps[j]),
      .addr  (addrs[j])
    );
  end

  assign compact_ok = ~|gap_pair;
  assign hit_any    = |hits;
  assign swap_any   = |swaps;

  always_comb begin
    addr_any = '0;
    for (int j = 0; j < MAX_RUNS; j++) begin
      addr_any = addr_any | addrs[j];
    end
  end

  // with a full table the gap above the top block has no cell of its own
  assign full      = ent[MAX_RUNS-1].valid;
  assign tail_need = {1'b0, {1'b0, ent[MAX_RUNS-1].start} + {1'b0, ent[MAX_RUNS-1].len}} +
                     {2'b0, p_len};
  assign tail_fit  = full && (tail_need <= {2'b0, eff_size});
  assign fit_any   = hit_any || tail_fit;
  assign key_next  = hit_any ? fkey : (fkey | bit_mask);

  assign fifo_full = (fifo_count == CW'(MAX_WAIT));
  assign push      = (state == S_FIT_ANY) && !p_fifo && !fit_any && !fifo_full;
  assign pop       = (state == S_INS) && p_fifo;
  assign in_ready  = (state == S_IDLE);

  ffta_wait_fifo #(
    .DEPTH (MAX_WAIT)
  ) u_wait (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_len (p_len),
    .push_dur (p_dur),
    .pop      (pop),
    .head_len (head_len),
    .head_dur (head_dur),
    .count    (fifo_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      last_time    <= '0;
      waited_total <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_mode  <= in_data.mode;
            item_time  <= {1'b0, in_data.arrival_time};
            item_len   <= in_data.length;
            item_dur   <= in_data.duration;
            limit      <= in_data.mode ? ffta_pkg::TIME_MAX : {1'b0, in_data.arrival_time};
            res_placed <= 1'b0;
            res_addr   <= '0;
            res_ovf    <= 1'b0;
            fkey       <= '0;
            hi_mask    <= '0;
            bit_mask   <= '0;
            state      <= S_REL_ANY;
          end
        end
        S_REL_ANY: begin
          if (hit_any) begin
            bit_mask <= ffta_pkg::TIME_TOP;
            state    <= S_REL_BIT;
          end else if (item_mode) begin
            state <= S_DONE;
          end else begin
            p_len  <= item_len;
            p_dur  <= item_dur;
            p_now  <= item_time;
            p_fifo <= 1'b0;
            state  <= S_FIT_ANY;
          end
        end
        S_REL_BIT: begin
          // settle one bit of the earliest due release time, top bit first
          fkey <= key_next;
          if (bit_mask[0]) begin
            state <= S_DEL;
          end else begin
            hi_mask  <= hi_mask | bit_mask;
            bit_mask <= bit_mask >> 1;
          end
        end
        S_DEL: begin
          last_time <= fkey;
          p_now     <= fkey;
          phase     <= 1'b0;
          quiet     <= 1'b0;
          state     <= S_COMPACT;
        end
        S_COMPACT: begin
          phase <= ~phase;
          quiet <= !swap_any;
          if (!swap_any && quiet) begin
            state <= S_SERVE;
          end
        end
        S_SERVE: begin
          fkey     <= '0;
          hi_mask  <= '0;
          bit_mask <= '0;
          state    <= (fifo_count == '0) ? S_REL_ANY : S_HEAD;
        end
        S_HEAD: begin
          p_len  <= head_len;
          p_dur  <= head_dur;
          p_fifo <= 1'b1;
          state  <= S_FIT_ANY;
        end
        S_FIT_ANY: begin
          if (fit_any && !full) begin
            bit_mask <= IDX_TOP;
            state    <= S_FIT_BIT;
          end else if (p_fifo) begin
            // head stays queued; go look for the next release batch
            state <= S_REL_ANY;
          end else begin
            if (fit_any || fifo_full) begin
              res_ovf <= 1'b1;
            end else if (waited_total < ffta_pkg::COUNT_MAX) begin
              waited_total <= waited_total + 20'd1;
            end
            state <= S_DONE;
          end
        end
        S_FIT_BIT: begin
          // settle one bit of the lowest fitting cell index
          fkey <= key_next;
          if (bit_mask[0]) begin
            state <= S_INS;
          end else begin
            hi_mask  <= hi_mask | bit_mask;
            bit_mask <= bit_mask >> 1;
          end
        end
        S_INS: begin
          if (p_fifo) begin
            state <= S_SERVE;
          end else begin
            res_placed <= 1'b1;
            res_addr   <= addr_any;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.placed_now        <= res_placed;
            out_data.start_address     <= res_addr[29:0];
            out_data.last_release_time <= last_time;
            out_data.queued_total      <= waited_total;
            out_data.overflow          <= res_ovf;
            out_valid                  <= 1'b1;
            state                      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFTA_CHECK(a_compact_at_fit, state == S_FIT_ANY, compact_ok, "run table has a hole below a block")
  `FFTA_CHECK(a_no_insert_full, state == S_INS, !ent[MAX_RUNS-1].valid, "insert into full run table")
  `FFTA_CHECK(a_search_bit, state == S_REL_BIT || state == S_FIT_BIT, $onehot(bit_mask), "search bit lost")
  `FFTA_CHECK_NEXT(a_result_load, state == S_DONE && (!out_valid || out_ready), out_valid && state == S_IDLE, "result not loaded")

endmodule
